// ===== src/fmprt_pkg.sv =====
`timescale 1ns / 1ps
package fmprt_pkg;
    localparam int IN_DATA_W = 136;
    localparam int OUT_DATA_W = 16;

    localparam logic [1:0] REQ_INSERT   = 2'd0;
    localparam logic [1:0] REQ_DELETE   = 2'd1;
    localparam logic [1:0] REQ_MODIFY   = 2'd2;
    localparam logic [1:0] REQ_CLASSIFY = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_ICMP = 8'd1;

    typedef struct packed {
        logic [5:0]  flags;
        logic [15:0] port_b;
        logic [15:0] port_a;
        logic [5:0]  prefix_b;
        logic [31:0] addr_b;
        logic [5:0]  prefix_a;
        logic [31:0] addr_a;
    } t_rule;

    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        logic [5:0] l;
        l = (len > 6'd32) ? 6'd32 : len;
        if (l == 6'd0) begin
            prefix_mask = 32'd0;
        end else begin
            prefix_mask = 32'hFFFF_FFFF << (6'd32 - l);
        end
    endfunction
endpackage

// ===== src/first_match_packet_rule_table.sv =====
`timescale 1ns / 1ps
// first-match packet rule table: ordered acl of up to MAX_RULES rules
// input channel s_axis: one beat per request (insert, delete, modify, classify)
// output channel m_axis: one beat per request with verdict and status
// rules sit in one memory with one write port and one registered read port; a
// single sequencer walks it one entry at a time
// classify: reads rules in order (read in S_RD, compare in S_CMP) and stops at
//   the first match; the result beat follows in S_OUT
// insert: each moved entry is read (S_INS_RD) and written one slot up (S_INS_WR), then the new rule is written
// delete: each later entry is read (S_DEL_RD) and written one slot down (S_DEL_WR)
// modify is a single write in S_INS_WR
// after each result beat the sequencer returns to S_IDLE to take the next request
// s_axis_tready is high only when idle and no result is pending
// a stalled receiver holds the result register and blocks the next request
// reset clears the rule count and the sequencer; memory contents are left as is
module first_match_packet_rule_table #(
    parameter int MAX_RULES = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // req_type, position, addr_a, prefix_a, addr_b, prefix_b, proto, port_a,
    // port_b, rule_flags (low bit up), zero-filled to 136 bits
    input  logic [fmprt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // permit, matched, match_index, status (low bit up), zero-filled
    output logic [fmprt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import fmprt_pkg::*;

    localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW = $clog2(MAX_RULES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_CMP, S_INS_RD, S_INS_WR, S_DEL_RD, S_DEL_WR, S_OUT
    } t_state;

    t_rule r_mem [MAX_RULES];
    t_rule r_rdata;

    t_state     r_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [1:0]    r_req;
    logic [CW-1:0] r_sel;
    t_rule         r_in;
    logic [7:0]    r_proto;
    logic          r_permit, r_matched;
    logic [6:0]    r_mindex;
    logic [1:0]    r_status;

    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    t_rule         mem_wd;

    // unpack request
    logic [1:0]  in_req;
    logic [6:0]  in_pos;
    t_rule       in_rule;
    assign in_req            = s_axis_tdata[1:0];
    assign in_pos            = s_axis_tdata[8:2];
    assign in_rule.addr_a    = s_axis_tdata[40:9];
    assign in_rule.prefix_a  = s_axis_tdata[46:41];
    assign in_rule.addr_b    = s_axis_tdata[78:47];
    assign in_rule.prefix_b  = s_axis_tdata[84:79];
    assign in_rule.port_a    = s_axis_tdata[108:93];
    assign in_rule.port_b    = s_axis_tdata[124:109];
    assign in_rule.flags     = s_axis_tdata[130:125];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {5'd0, r_status, r_mindex, r_matched, r_permit};

    // rule compare against registered read data
    logic hit, proto_hit;
    always_comb begin
        case (r_proto)
            PROTO_TCP:  proto_hit = r_rdata.flags[0];
            PROTO_UDP:  proto_hit = r_rdata.flags[1];
            PROTO_ICMP: proto_hit = r_rdata.flags[2];
            default:    proto_hit = 1'b0;
        endcase
        hit = ((r_in.addr_a & prefix_mask(r_rdata.prefix_a)) == r_rdata.addr_a)
           && ((r_in.addr_b & prefix_mask(r_rdata.prefix_b)) == r_rdata.addr_b)
           && proto_hit
           && (!r_rdata.flags[4] || r_in.port_a == r_rdata.port_a)
           && (!r_rdata.flags[5] || r_in.port_b == r_rdata.port_b);
    end

    // memory port control
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_idx[AW-1:0];
        mem_wd = r_rdata;
        mem_ra = r_idx[AW-1:0];
        case (r_state)
            S_INS_RD: mem_ra = AW'(r_idx - CW'(1));
            S_INS_WR: begin
                mem_we = 1'b1;
                if (r_idx == r_sel) begin
                    mem_wd = r_in;
                end
            end
            S_DEL_RD: mem_ra = AW'(r_idx + CW'(1));
            S_DEL_WR: mem_we = 1'b1;
            default:  mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    logic [CW-1:0] pos_c, sel1;
    assign pos_c = (in_pos > 7'(MAX_RULES)) ? CW'(MAX_RULES + 1 > (1 << CW) - 1 ?
                   (1 << CW) - 1 : MAX_RULES + 1) : CW'(in_pos);
    assign sel1  = (pos_c == '0) ? CW'(1) : pos_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_req     <= in_req;
                        r_in      <= in_rule;
                        r_proto   <= s_axis_tdata[92:85];
                        r_permit  <= 1'b0;
                        r_matched <= 1'b0;
                        r_mindex  <= '0;
                        case (in_req)
                            REQ_INSERT: begin
                                if (in_pos > 7'(r_count)) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_OUT;
                                end else if (r_count == CW'(MAX_RULES)) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_status <= ST_OK;
                                    r_sel    <= pos_c;
                                    r_idx    <= r_count;
                                    r_state  <= (r_count == pos_c) ? S_INS_WR : S_INS_RD;
                                end
                            end
                            REQ_DELETE, REQ_MODIFY: begin
                                if (7'(sel1) > 7'(r_count) || in_pos > 7'(r_count)) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_OUT;
                                end else if (in_req == REQ_MODIFY) begin
                                    r_status <= ST_OK;
                                    r_idx    <= sel1 - CW'(1);
                                    r_sel    <= sel1 - CW'(1);
                                    r_state  <= S_INS_WR;
                                end else begin
                                    r_status <= ST_OK;
                                    r_idx    <= sel1 - CW'(1);
                                    r_state  <= (sel1 == r_count) ? S_OUT : S_DEL_RD;
                                    r_count  <= r_count - CW'(1);
                                end
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_idx    <= '0;
                                r_state  <= (r_count == '0) ? S_OUT : S_RD;
                            end
                        endcase
                    end
                end
                S_RD: r_state <= S_CMP;
                S_CMP: begin
                    if (hit) begin
                        r_matched <= 1'b1;
                        r_permit  <= r_rdata.flags[3];
                        r_mindex  <= 7'(r_idx + CW'(1));
                        r_state   <= S_OUT;
                    end else if (r_idx + CW'(1) >= r_count) begin
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_RD;
                    end
                end
                S_INS_RD: r_state <= S_INS_WR;
                S_INS_WR: begin
                    if (r_idx == r_sel) begin
                        if (r_req == REQ_INSERT) begin
                            r_count <= r_count + CW'(1);
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= r_idx - CW'(1);
                        r_state <= (r_idx - CW'(1) == r_sel) ? S_INS_WR : S_INS_RD;
                    end
                end
                S_DEL_RD: r_state <= S_DEL_WR;
                S_DEL_WR: begin
                    if (r_idx + CW'(1) >= r_count) begin
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_DEL_RD;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== dv/fmprt_checker.sv =====
`timescale 1ns / 1ps
module fmprt_checker
    import fmprt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic [IN_DATA_W-1:0]  i_req_data,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic [OUT_DATA_W-1:0] i_res_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_results,
    output int                    o_matches
);
    localparam int DEPTH = 64;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] index;
        logic       matched;
        logic       permit;
    } t_verdict;

    t_rule      rules [DEPTH];
    int         count = 0;
    int         err_cnt = 0;
    int         pend_cnt = 0;
    int         res_cnt = 0;
    int         match_cnt = 0;
    t_verdict   verdict_q[$];

    assign o_errors  = err_cnt;
    assign o_pending = pend_cnt;
    assign o_results = res_cnt;
    assign o_matches = match_cnt;

    function automatic logic [31:0] mask_of(input logic [5:0] len);
        logic [5:0] l;
        l = (len > 6'd32) ? 6'd32 : len;
        return (l == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (6'd32 - l));
    endfunction

    function automatic logic proto_allowed(input logic [7:0] pr, input logic [5:0] f);
        if (pr == PROTO_TCP) return f[0];
        if (pr == PROTO_UDP) return f[1];
        if (pr == PROTO_ICMP) return f[2];
        return 1'b0;
    endfunction

    // applies one request to the shadow table and returns its verdict
    function automatic t_verdict apply_request(input logic [IN_DATA_W-1:0] d);
        t_verdict   v;
        logic [1:0] req;
        int         pos;
        int         sel;
        t_rule      r;
        v   = '0;
        req = d[1:0];
        pos = d[8:2];
        r.addr_a   = d[40:9];
        r.prefix_a = d[46:41];
        r.addr_b   = d[78:47];
        r.prefix_b = d[84:79];
        r.port_a   = d[108:93];
        r.port_b   = d[124:109];
        r.flags    = d[130:125];
        sel = (pos == 0) ? 1 : pos;
        case (req)
            REQ_INSERT: begin
                if (pos > count) v.status = ST_RANGE;
                else if (count >= DEPTH) v.status = ST_FULL;
                else begin
                    for (int i = count; i > pos; i--) rules[i] = rules[i-1];
                    rules[pos] = r;
                    count++;
                end
            end
            REQ_DELETE: begin
                if (sel > count) v.status = ST_RANGE;
                else begin
                    for (int i = sel - 1; i + 1 < count; i++) rules[i] = rules[i+1];
                    count--;
                end
            end
            REQ_MODIFY: begin
                if (sel > count) v.status = ST_RANGE;
                else rules[sel-1] = r;
            end
            default: begin
                for (int i = 0; i < count; i++) begin
                    if ((r.addr_a & mask_of(rules[i].prefix_a)) != rules[i].addr_a) continue;
                    if ((r.addr_b & mask_of(rules[i].prefix_b)) != rules[i].addr_b) continue;
                    if (!proto_allowed(d[92:85], rules[i].flags)) continue;
                    if (rules[i].flags[4] && r.port_a != rules[i].port_a) continue;
                    if (rules[i].flags[5] && r.port_b != rules[i].port_b) continue;
                    v.matched = 1'b1;
                    v.permit  = rules[i].flags[3];
                    v.index   = 7'(i + 1);
                    break;
                end
            end
        endcase
        return v;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_verdict got;
        t_verdict want;
        if (i_rst_n && i_req_valid && i_req_ready)
            verdict_q.push_back(apply_request(i_req_data));
        if (i_rst_n && i_res_valid && i_res_ready) begin
            got = i_res_data[10:0];
            res_cnt++;
            if (verdict_q.size() == 0) begin
                report("unexpected beat", 1, 0);
            end else begin
                want = verdict_q.pop_front();
                if (want.matched) match_cnt++;
                if (got.permit != want.permit) report("permit", got.permit, want.permit);
                if (got.matched != want.matched) report("matched", got.matched, want.matched);
                if (got.index != want.index) report("match_index", got.index, want.index);
                if (got.status != want.status) report("status", got.status, want.status);
            end
        end
        pend_cnt = verdict_q.size();
    end
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import fmprt_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    int                    errors, pending, results, match_count;
    int                    idle_cycles;
    int                    hold_off;
    bit                    hold_req;
    bit                    hold_taken;
    int                    table_size;
    logic [31:0]           rule_src [$];
    logic [31:0]           rule_dst [$];

    first_match_packet_rule_table uut (.*);

    fmprt_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready), .i_req_data(s_axis_tdata),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready), .i_res_data(m_axis_tdata),
        .o_errors(errors), .o_pending(pending), .o_results(results), .o_matches(match_count)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    function automatic logic [IN_DATA_W-1:0] pack_req(
        input logic [1:0] req, input logic [6:0] pos, input logic [31:0] sa,
        input logic [5:0] pa, input logic [31:0] da, input logic [5:0] pb,
        input logic [7:0] pr, input logic [15:0] sp, input logic [15:0] dp,
        input logic [5:0] fl);
        return {{(IN_DATA_W-131){1'b0}}, fl, dp, sp, pr, pb, da, pa, sa, pos, req};
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // address with nothing set below its prefix, so the rule can match
    function automatic logic [31:0] aligned(input logic [31:0] a, input logic [5:0] p);
        logic [5:0] l;
        l = (p > 6'd32) ? 6'd32 : p;
        return (l == 0) ? 32'd0 : a & (32'hFFFF_FFFF << (6'd32 - l));
    endfunction

    // valid stays high into the next beat when no gap follows
    task automatic send(input logic [IN_DATA_W-1:0] d);
        int gap;
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] pick_proto();
        case ($urandom_range(0, 7))
            0, 1, 2: return PROTO_TCP;
            3, 4:    return PROTO_UDP;
            5:       return PROTO_ICMP;
            default: return 8'($urandom);
        endcase
    endfunction

    // random request biased toward rules and packets that actually match
    task automatic random_request(input bit grow);
        logic [5:0]  pa, pb, fl;
        logic [31:0] sa, da;
        logic [1:0]  req;
        int          r, k;
        r  = $urandom_range(0, 99);
        pa = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 32));
        pb = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 32));
        sa = $urandom;
        da = $urandom;
        fl = 6'($urandom);
        if (grow ? r < 60 : r < 20) req = REQ_INSERT;
        else if (grow ? r < 63 : r < 35) req = REQ_DELETE;
        else if (r < 45) req = REQ_MODIFY;
        else req = REQ_CLASSIFY;
        if (req != REQ_CLASSIFY && $urandom_range(0, 7) != 0) begin
            sa = aligned(sa, pa);
            da = aligned(da, pb);
        end
        if (req == REQ_CLASSIFY && rule_src.size() > 0 && $urandom_range(0, 3) != 0) begin
            k  = $urandom_range(0, rule_src.size() - 1);
            sa = rule_src[k] | ($urandom & 32'h0000_00FF);
            da = rule_dst[k] | ($urandom & 32'h0000_00FF);
        end
        if (req == REQ_INSERT || req == REQ_MODIFY) begin
            rule_src.push_back(sa);
            rule_dst.push_back(da);
            if (rule_src.size() > 32) begin
                void'(rule_src.pop_front());
                void'(rule_dst.pop_front());
            end
        end
        send(pack_req(req, 7'($urandom_range(0, table_size + 2)), sa, pa, da, pb,
                      pick_proto(), ($urandom_range(0, 1) ? 16'($urandom) : 16'd80),
                      ($urandom_range(0, 1) ? 16'($urandom) : 16'd443), fl));
        if (req == REQ_INSERT && table_size < 64) table_size++;
        if (req == REQ_DELETE && table_size > 0) table_size--;
    endtask

    // receiver: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_off      <= 0;
            hold_taken    <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off      <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_off      <= 300;
            hold_taken    <= 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) < 70) ||
                             ($urandom_range(0, 99) < 2 ? 1'b0 : 1'b1) && 1'b0;
        end
    end

    // watchdog: cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("timeout");
            $display("FAIL first_match_packet_rule_table");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        hold_req      = 1'b0;
        table_size    = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: edits on an empty table, then extremes and special cases
        send(pack_req(REQ_DELETE, 7'd0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(pack_req(REQ_MODIFY, 7'd1, 0, 0, 0, 0, 0, 0, 0, 0));
        send(pack_req(REQ_CLASSIFY, 7'd0, '1, 0, '1, 0, PROTO_TCP, '1, '1, 0));
        send(pack_req(REQ_INSERT, 7'd1, 0, 0, 0, 0, 0, 0, 0, 6'h3F));
        // catch-all permit for any tcp
        send(pack_req(REQ_INSERT, 7'd0, 0, 6'd0, 0, 6'd0, 0, 0, 0, 6'b001001));
        // exact host match with oversized prefixes and both ports given
        send(pack_req(REQ_INSERT, 7'd0, '1, 6'd63, '1, 6'd40, 0, '1, '1, 6'b110111));
        // rule with bits below its prefix never matches
        send(pack_req(REQ_INSERT, 7'd2, 32'h0A00_00FF, 6'd8, 0, 0, 0, 0, 0, 6'b001111));
        send(pack_req(REQ_CLASSIFY, 0, '1, 0, '1, 0, PROTO_TCP, '1, '1, 0));
        send(pack_req(REQ_CLASSIFY, 0, '1, 0, '1, 0, PROTO_UDP, '1, 16'd0, 0));
        send(pack_req(REQ_CLASSIFY, 0, 32'h0A00_00FF, 0, 0, 0, PROTO_ICMP, 0, 0, 0));
        send(pack_req(REQ_CLASSIFY, 0, 0, 0, 0, 0, PROTO_TCP, 0, 0, 0));
        send(pack_req(REQ_CLASSIFY, 0, 0, 0, 0, 0, 8'hFF, 0, 0, 0));
        send(pack_req(REQ_MODIFY, 7'd0, 0, 6'd32, 0, 6'd1, 0, 0, 0, 6'b000110));
        send(pack_req(REQ_CLASSIFY, 0, 0, 0, 32'h7FFF_FFFF, 0, PROTO_ICMP, 0, 0, 0));
        send(pack_req(REQ_MODIFY, 7'd9, 0, 0, 0, 0, 0, 0, 0, 0));
        send(pack_req(REQ_DELETE, 7'd3, 0, 0, 0, 0, 0, 0, 0, 0));
        send(pack_req(REQ_DELETE, 7'd5, 0, 0, 0, 0, 0, 0, 0, 0));
        send(pack_req(REQ_CLASSIFY, 0, '1, 0, '1, 0, PROTO_TCP, '1, '1, 0));
        send(pack_req(REQ_DELETE, 7'd0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(pack_req(REQ_DELETE, 7'd0, 0, 0, 0, 0, 0, 0, 0, 0));
        table_size = 0;

        // fill to capacity, probe full table, then drain partly
        for (int i = 0; i < 68; i++) random_request(1'b1);
        // front inserts always succeed until the table is full
        repeat (66) send(pack_req(REQ_INSERT, 7'd0, 0, 0, 0, 0, 0, 0, 0, 6'($urandom)));
        table_size = 64;
        send(pack_req(REQ_INSERT, 7'd64, 0, 0, 0, 0, 0, 0, 0, 0));
        send(pack_req(REQ_INSERT, 7'd65, 0, 0, 0, 0, 0, 0, 0, 0));
        send(pack_req(REQ_CLASSIFY, 0, 0, 0, 0, 0, 8'd2, 0, 0, 0));

        // long receiver hold-off while requests keep coming
        hold_req = 1'b1;
        for (int i = 0; i < 6; i++) random_request(1'b0);
        // sender waits for everything to drain
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        for (int i = 0; i < 990; i++) random_request(i % 300 < 150);

        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        $display("covered %0d results, %0d classified with a match", results, match_count);
        $display("edits on empty, partial and full tables with range and full cases");
        if (errors == 0)
            $display("PASS first_match_packet_rule_table");
        else
            $display("FAIL first_match_packet_rule_table");
        $finish;
    end
endmodule
